@@ sv/unique_values_first_occurrence_core_defines.svh @@
// Assertion macros for the unique-value core checker.
`ifndef UNIQUE_VALUES_FIRST_OCCURRENCE_CORE_DEFINES_SVH
`define UNIQUE_VALUES_FIRST_OCCURRENCE_CORE_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, off during reset.
`define UVFO_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, off during reset.
`define UVFO_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/uvfo_pkg.sv @@
// Shared types and constants for the unique-value core.
package uvfo_pkg;

  localparam int unsigned MaxEntriesDef = 32;
  localparam int unsigned CountBitsDef  = 16;

  localparam logic KindIndex = 1'b0;
  localparam logic KindEntry = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MATCH,
    ST_UPDATE,
    ST_DREAD,
    ST_DEMIT
  } state_e;

  typedef struct packed {
    logic signed [63:0] value;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic               kind;
    logic [4:0]         position;
    logic signed [63:0] unique_value;
    logic [15:0]        occurrences;
    logic [5:0]         unique_total;
    logic               table_full;
    logic               final_res;
  } out_item_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic match;
    logic update;
    logic dread;
    logic demit;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic last;
    logic dump_done;
  } status_t;

endpackage

@@ sv/unique_values_first_occurrence_core.sv @@
// Top level of the streaming unique-value core.
// Streaming unique-value table. Each item (a signed 64-bit value plus a last
// flag) enters when start_i is high and busy_o is low. The value is compared
// in parallel against every stored distinct value while the count RAM read
// is issued; a miss appends it, and in the next cycle its occurrence count
// is raised (saturating) and written back. The inverse-index result follows
// in the cycle after that on res_o, strobed by res_valid_o for a single cycle;
// the receiver cannot stall it, so it must take every strobed result. Items
// run back to back: a new item is accepted in the update cycle of a non-last
// previous one, and that pace is set by the registered read of the count
// RAM. An item marked last is followed by a dump of the whole table, each
// entry by a RAM read then an emit, busy_o high throughout; the final entry
// carries final_res and the table is then empty. A new value arriving at a
// full table reports table_full with position 0 and is not stored. No
// clearing pass is needed after reset.
module unique_values_first_occurrence_core
  import uvfo_pkg::*;
#(
  parameter int unsigned MaxEntries = MaxEntriesDef,
  parameter int unsigned CountBits  = CountBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      start_i,
  output logic      busy_o,
  input  in_item_t  in_i,
  output logic      res_valid_o,
  output out_item_t res_o
);

  cmd_t    cmd;
  status_t status;

  uvfo_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .status_i (status),
    .busy_o   (busy_o),
    .cmd_o    (cmd)
  );

  uvfo_dp #(
    .MaxEntries (MaxEntries),
    .CountBits  (CountBits)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_i        (in_i),
    .status_o    (status),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

endmodule

@@ sv/uvfo_ram.sv @@
// Generic single-port-write, registered-read RAM.
module uvfo_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 32,
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/uvfo_ctrl.sv @@
// Sequencing state machine for the unique-value core.
module uvfo_ctrl
  import uvfo_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start_i,
  input  status_t status_i,
  output logic    busy_o,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;
  logic   accept;

  // Idle, or finishing a non-last item: the next item may enter.
  assign busy_o = !((state_q == ST_IDLE) || (state_q == ST_UPDATE && !status_i.last));
  assign accept = start_i && !busy_o;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:   if (accept) state_d = ST_MATCH;
      ST_MATCH:  state_d = ST_UPDATE;
      ST_UPDATE: begin
        if (status_i.last) begin
          state_d = ST_DREAD;
        end else if (accept) begin
          state_d = ST_MATCH;
        end else begin
          state_d = ST_IDLE;
        end
      end
      ST_DREAD:  state_d = ST_DEMIT;
      ST_DEMIT:  state_d = status_i.dump_done ? ST_IDLE : ST_DREAD;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.load   = accept;
    unique case (state_q)
      ST_MATCH:  cmd_o.match  = 1'b1;
      ST_UPDATE: cmd_o.update = 1'b1;
      ST_DREAD:  cmd_o.dread  = 1'b1;
      ST_DEMIT:  cmd_o.demit  = 1'b1;
      default:   ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ sv/uvfo_dp.sv @@
// Datapath: value table, match logic, count RAM and result register.
module uvfo_dp
  import uvfo_pkg::*;
#(
  parameter int unsigned MaxEntries = MaxEntriesDef,
  parameter int unsigned CountBits  = CountBitsDef
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  cmd_t      cmd_i,
  input  in_item_t  in_i,
  output status_t   status_o,
  output logic      res_valid_o,
  output out_item_t res_o
);

  localparam int unsigned Iw = (MaxEntries > 1) ? $clog2(MaxEntries) : 1;
  localparam int unsigned Uw = $clog2(MaxEntries + 1);

  in_item_t           in_q;
  logic signed [63:0] values_q [MaxEntries];
  logic [Uw-1:0]      used_q;
  logic [Iw-1:0]      pos_q, idx_q;
  logic               full_q, new_q;
  logic               res_valid_q;
  out_item_t          res_q, res_d;

  logic [MaxEntries-1:0] hit_vec;
  logic                  hit_any, room;
  logic [Iw-1:0]         hit_pos;
  logic [Uw-1:0]         idx_next;
  logic                  ram_we, ram_re;
  logic [Iw-1:0]         ram_raddr;
  logic [CountBits-1:0]  ram_rdata, cnt_inc, cnt_wdata;
  logic [31:0]           cnt_ext;

  // Parallel compare over live entries; lowest hit wins (entries are distinct).
  always_comb begin
    hit_pos = '0;
    for (int i = 0; i < MaxEntries; i++) begin
      hit_vec[i] = (Uw'(i) < used_q) && (values_q[i] == in_q.value);
    end
    for (int i = MaxEntries - 1; i >= 0; i--) begin
      if (hit_vec[i]) hit_pos = Iw'(i);
    end
  end

  assign hit_any  = |hit_vec;
  assign room     = used_q < Uw'(MaxEntries);
  assign idx_next = Uw'(idx_q) + Uw'(1);

  assign status_o.last      = in_q.last;
  assign status_o.dump_done = (idx_next == used_q);

  // Count RAM: read at match or dump, write back at update unless the table was full.
  assign ram_re    = cmd_i.match || cmd_i.dread;
  assign ram_raddr = cmd_i.dread ? idx_q : hit_pos;
  assign ram_we    = cmd_i.update && !full_q;
  assign cnt_inc   = (&ram_rdata) ? ram_rdata : ram_rdata + CountBits'(1);
  assign cnt_wdata = new_q ? CountBits'(1) : cnt_inc;
  assign cnt_ext   = 32'(ram_rdata);

  uvfo_ram #(
    .Width (CountBits),
    .Depth (MaxEntries)
  ) u_cnt_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (pos_q),
    .wdata_i (cnt_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    res_d = '0;
    if (cmd_i.update) begin
      res_d.kind         = KindIndex;
      res_d.position     = 5'(pos_q);
      res_d.unique_total = 6'(used_q);
      res_d.table_full   = full_q;
      res_d.final_res    = !in_q.last;
    end else begin
      res_d.kind         = KindEntry;
      res_d.position     = 5'(idx_q);
      res_d.unique_value = values_q[idx_q];
      res_d.occurrences  = cnt_ext[15:0];
      res_d.unique_total = 6'(used_q);
      res_d.final_res    = status_o.dump_done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q      <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= cmd_i.update || cmd_i.demit;
      if (cmd_i.match && !hit_any && room) begin
        used_q <= used_q + Uw'(1);
      end else if (cmd_i.demit && status_o.dump_done) begin
        used_q <= '0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      in_q <= in_i;
    end
    if (cmd_i.match) begin
      if (hit_any) begin
        pos_q  <= hit_pos;
        new_q  <= 1'b0;
        full_q <= 1'b0;
      end else if (room) begin
        pos_q  <= used_q[Iw-1:0];
        new_q  <= 1'b1;
        full_q <= 1'b0;
        values_q[used_q[Iw-1:0]] <= in_q.value;
      end else begin
        pos_q  <= '0;
        new_q  <= 1'b0;
        full_q <= 1'b1;
      end
    end
    if (cmd_i.update) begin
      idx_q <= '0;
    end else if (cmd_i.demit) begin
      idx_q <= idx_q + Iw'(1);
    end
    if (cmd_i.update || cmd_i.demit) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

@@ sv/uvfo_checker.sv @@
// Port-level assertions for the unique-value core, with bind.
`include "unique_values_first_occurrence_core_defines.svh"

module uvfo_checker
  import uvfo_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      start_i,
  input logic      busy_o,
  input logic      res_valid_o,
  input out_item_t res_o
);

  logic in_take;
  logic full_res;
  logic entry_res;
  logic entry_open;

  assign in_take    = start_i && !busy_o;
  assign full_res   = res_valid_o && res_o.kind == KindIndex && res_o.table_full;
  assign entry_res  = res_valid_o && res_o.kind == KindEntry;
  assign entry_open = entry_res && !res_o.final_res;

  `UVFO_ASSERT_NEXT(a_accept_busy, in_take, busy_o, "item accepted but core not busy")
  `UVFO_ASSERT_NOW(a_full_pos0, full_res, res_o.position == 5'd0, "table_full at nonzero position")
  `UVFO_ASSERT_NOW(a_entry_ok, entry_res, !res_o.table_full && res_o.unique_total != 6'd0, "bad entry")
  `UVFO_ASSERT_NOW(a_dump_busy, entry_open, busy_o, "dump not finished but core idle")

endmodule

bind unique_values_first_occurrence_core uvfo_checker u_checker (.*);
